@@ hdl/tga_rle_pixel_decoder_macros.svh @@
// ---------------------------------------------------------------------------
// tga rle pixel decoder assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

`ifndef SYNTH
`define TGA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tga rle decoder check failed");
`define TGA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tga rle decoder check failed");
`else
`define TGA_ASSERT(lbl, prop)
`define TGA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ hdl/tga_rle_pkg.sv @@
// ---------------------------------------------------------------------------
// tga rle decoder package
// shared types, register indexes and constants
// ---------------------------------------------------------------------------
package tga_rle_pkg;

  localparam logic [7:0] RUN_BIAS = 8'h81;

  typedef enum logic [1:0] {
    REG_PIXEL_BYTES   = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2,
    REG_TOP_TO_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PLACE = 2'b10
  } state_t;

  typedef struct packed {
    logic take_word;
    logic place_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic burst_start;
    logic burst_end;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/tga_rle_ctrl.sv @@
// ---------------------------------------------------------------------------
// tga rle decoder controller
// accepts stream words and sequences pixel placement one pixel per cycle while the output register has room
// ---------------------------------------------------------------------------
module tga_rle_ctrl
  import tga_rle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state_r;
  state_t state_nxt;

  assign in_tready      = (state_r == ST_IDLE);
  assign cmd.take_word  = (state_r == ST_IDLE) && in_tvalid;
  assign cmd.place_step = (state_r == ST_PLACE) && status.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take_word && status.burst_start) state_nxt = ST_PLACE;
      end
      ST_PLACE: begin
        if (cmd.place_step && status.burst_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/tga_rle_dp.sv @@
// ---------------------------------------------------------------------------
// tga rle decoder datapath
// packet parsing, pixel assembly, position tracking and the output register
// ---------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_dp
  import tga_rle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte,
  input  ctl_cmd_t    cmd,
  output dp_status_t  status,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [31:0] out_first,
  output logic [31:0] out_second,
  output logic        out_second_valid,
  output logic [15:0] out_row,
  output logic [15:0] out_col,
  output logic        out_done,
  output logic        out_last
);

  // configuration
  logic [2:0]  pixel_bytes_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic        ttb_r;

  // decode state
  logic [7:0]  packet_left_r, packet_left_nxt;
  logic        is_run_r, is_run_nxt;
  logic [1:0]  bpos_r, bpos_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [15:0] cur_col_r, cur_col_nxt;
  logic [15:0] cur_row_r, cur_row_nxt;
  logic        finished_r, finished_nxt;
  logic [7:0]  remain_r, remain_nxt;

  // pair slot
  logic        slot_full_r, slot_full_nxt;
  logic [15:0] slot_row_r, slot_row_nxt;
  logic [15:0] slot_col_r, slot_col_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_first_r, out_first_nxt;
  logic [31:0] out_second_r, out_second_nxt;
  logic        out_sv_r, out_sv_nxt;
  logic [15:0] out_row_r, out_row_nxt;
  logic [15:0] out_col_r, out_col_nxt;
  logic        out_done_r, out_done_nxt;
  logic        out_last_r, out_last_nxt;

  logic [2:0]  pb_eff;
  logic        blocked;
  logic        is_header;
  logic [31:0] gather_add;
  logic        completes;
  logic        fail;
  logic [16:0] col_inc;
  logic        wrap;
  logic [15:0] row_adv;
  logic        done_now;
  logic [7:0]  remain_dec;
  logic        stop;
  logic        emit;
  logic [15:0] pix_row;

  always_comb begin
    priority if (pixel_bytes_r == 3'd0) pb_eff = 3'd1;
    else if (pixel_bytes_r > 3'd4)      pb_eff = 3'd4;
    else                                pb_eff = pixel_bytes_r;
  end

  assign blocked    = finished_r || (width_r == 16'd0) || (height_r == 16'd0);
  assign is_header  = (packet_left_r == 8'd0);
  assign gather_add = gather_r | ({24'd0, in_byte} << {bpos_r, 3'b000});
  assign completes  = (({1'b0, bpos_r}) + 3'd1) >= pb_eff;

  assign fail       = finished_r || (cur_row_r >= height_r);
  assign col_inc    = {1'b0, cur_col_r} + 17'd1;
  assign wrap       = col_inc >= {1'b0, width_r};
  assign row_adv    = wrap ? cur_row_r + 16'd1 : cur_row_r;
  assign done_now   = row_adv >= height_r;
  assign remain_dec = remain_r - 8'd1;
  assign stop       = fail || (remain_dec == 8'd0) || done_now;
  assign emit       = cmd.place_step && !fail && (slot_full_r || stop);
  assign pix_row    = ttb_r ? cur_row_r : height_r - 16'd1 - cur_row_r;

  assign status.burst_start = in_cmd && !blocked && !is_header && completes;
  assign status.burst_end   = stop;
  assign status.out_free    = !out_valid_r || out_tready;

  always_comb begin
    packet_left_nxt = packet_left_r;
    is_run_nxt      = is_run_r;
    bpos_nxt        = bpos_r;
    gather_nxt      = gather_r;
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    finished_nxt    = finished_r;
    remain_nxt      = remain_r;
    slot_full_nxt   = slot_full_r;
    slot_row_nxt    = slot_row_r;
    slot_col_nxt    = slot_col_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_sv_nxt      = out_sv_r;
    out_row_nxt     = out_row_r;
    out_col_nxt     = out_col_r;
    out_done_nxt    = out_done_r;
    out_last_nxt    = out_last_r;

    if (cmd.take_word) begin
      if (!in_cmd) begin
        packet_left_nxt = 8'd0;
        is_run_nxt      = 1'b0;
        bpos_nxt        = 2'd0;
        gather_nxt      = 32'd0;
        cur_col_nxt     = 16'd0;
        cur_row_nxt     = 16'd0;
        finished_nxt    = 1'b0;
      end else if (!blocked) begin
        if (is_header) begin
          if (in_byte[7]) begin
            packet_left_nxt = in_byte + RUN_BIAS;
            is_run_nxt      = 1'b1;
          end else begin
            packet_left_nxt = in_byte + 8'd1;
            is_run_nxt      = 1'b0;
          end
          bpos_nxt   = 2'd0;
          gather_nxt = 32'd0;
        end else begin
          gather_nxt = gather_add;
          if (!completes) begin
            bpos_nxt = bpos_r + 2'd1;
          end else begin
            bpos_nxt        = 2'd0;
            remain_nxt      = is_run_r ? packet_left_r : 8'd1;
            packet_left_nxt = is_run_r ? 8'd0 : packet_left_r - 8'd1;
          end
        end
      end
    end

    if (cmd.place_step) begin
      if (fail) begin
        finished_nxt = 1'b1;
      end else begin
        cur_col_nxt  = wrap ? 16'd0 : col_inc[15:0];
        cur_row_nxt  = row_adv;
        finished_nxt = done_now;
        remain_nxt   = remain_dec;
        if (slot_full_r || stop) begin
          slot_full_nxt  = 1'b0;
          out_valid_nxt  = 1'b1;
          out_first_nxt  = gather_r;
          out_second_nxt = slot_full_r ? gather_r : 32'd0;
          out_sv_nxt     = slot_full_r;
          out_row_nxt    = slot_full_r ? slot_row_r : pix_row;
          out_col_nxt    = slot_full_r ? slot_col_r : cur_col_r;
          out_done_nxt   = done_now;
          out_last_nxt   = stop;
        end else begin
          slot_full_nxt = 1'b1;
          slot_row_nxt  = pix_row;
          slot_col_nxt  = cur_col_r;
        end
      end
      if (stop) gather_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r <= 3'd4;
      width_r       <= 16'd1;
      height_r      <= 16'd1;
      ttb_r         <= 1'b0;
      packet_left_r <= 8'd0;
      is_run_r      <= 1'b0;
      bpos_r        <= 2'd0;
      gather_r      <= 32'd0;
      cur_col_r     <= 16'd0;
      cur_row_r     <= 16'd0;
      finished_r    <= 1'b0;
      remain_r      <= 8'd0;
      slot_full_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_PIXEL_BYTES:   pixel_bytes_r <= cfg_wdata[2:0];
          REG_IMAGE_WIDTH:   width_r       <= cfg_wdata;
          REG_IMAGE_HEIGHT:  height_r      <= cfg_wdata;
          REG_TOP_TO_BOTTOM: ttb_r         <= cfg_wdata[0];
        endcase
      end
      packet_left_r <= packet_left_nxt;
      is_run_r      <= is_run_nxt;
      bpos_r        <= bpos_nxt;
      gather_r      <= gather_nxt;
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      finished_r    <= finished_nxt;
      remain_r      <= remain_nxt;
      slot_full_r   <= slot_full_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_row_r   <= slot_row_nxt;
    slot_col_r   <= slot_col_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_sv_r     <= out_sv_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_done_r   <= out_done_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid       = out_valid_r;
  assign out_first        = out_first_r;
  assign out_second       = out_second_r;
  assign out_second_valid = out_sv_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_done         = out_done_r;
  assign out_last         = out_last_r;

  `TGA_ASSERT(a_emit_needs_room, emit |-> (!out_valid_r || out_tready))
  `TGA_ASSERT(a_step_has_work, cmd.place_step |-> (remain_r != 8'd0))
  `TGA_ASSERT(a_no_pixel_after_full, (cmd.place_step && finished_r) |-> !emit)
  `TGA_ASSERT(a_pair_same_value,
              (out_valid_r && out_sv_r) |-> (out_first_r == out_second_r))

endmodule

@@ hdl/tga_rle_pixel_decoder.sv @@
// a lone pixel goes via ST_PLACE to the output register; longer runs fill the pair slot first
// a run of n pixels is placed one pixel per cycle while output has room, and input waits meanwhile
// header bytes, partial pixel bytes and new-image words are taken without leaving the idle state
// the output register lets input continue while the final result waits
// reset: synchronous active-low rst_n clears state and loads register defaults
// ---------------------------------------------------------------------------
// tga rle pixel decoder
// expands tga run-length packets into single pixels or pixel pairs tagged with row and column
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder
  import tga_rle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // first_pixel, second_pixel, pixel_row, pixel_col
  output logic [1:0]  out_tuser,  // second_valid, image_done
  output logic        out_tlast
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  logic [31:0] first_pixel;
  logic [31:0] second_pixel;
  logic        second_valid;
  logic [15:0] pixel_row;
  logic [15:0] pixel_col;
  logic        image_done;

  tga_rle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tga_rle_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_tuser),
    .in_byte          (in_tdata),
    .cmd              (cmd),
    .status           (status),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_first        (first_pixel),
    .out_second       (second_pixel),
    .out_second_valid (second_valid),
    .out_row          (pixel_row),
    .out_col          (pixel_col),
    .out_done         (image_done),
    .out_last         (out_tlast)
  );

  assign out_tdata = {pixel_col, pixel_row, second_pixel, first_pixel};
  assign out_tuser = {image_done, second_valid};

endmodule
